FILE: hw/rtl/hpfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpfa_pkg
// Shared types and constants of the hybrid page frame allocator: response
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hpfa_pkg;

   localparam int ADDR_W        = 32;
   localparam int ST_W          = 2;
   localparam int PC_W          = 13;
   localparam int PC_RESET      = 4096;
   localparam int MAP_WORD_BITS = 8;
   // largest page count after rounding down to whole map bytes
   localparam int PC_MAX_EFF    = 8184;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_OOM   = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } rsp_status_type;

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } req_cmd_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_STACK = 2'd1,
      SRC_SCAN  = 2'd2
   } res_src_type;

   typedef enum logic [2:0] {
      S_CLEAR   = 3'd0,
      S_IDLE    = 3'd1,
      S_EXEC    = 3'd2,
      S_POP     = 3'd3,
      S_SCAN    = 3'd4,
      S_FREE_WR = 3'd5,
      S_FINISH  = 3'd6
   } ctrl_state_type;

   typedef struct packed {
      logic           req_take;
      logic           stk_rd_en;
      logic           stk_wr_en;
      logic           scan_start;
      logic           scan_run;
      logic           map_free_rd;
      logic           map_free_wr;
      logic           clear_run;
      logic           res_load;
      res_src_type    res_src;
      rsp_status_type res_status;
      logic           rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd_free;
      logic stack_empty;
      logic stack_full;
      logic low_page;
      logic out_of_range;
      logic scan_hit;
      logic scan_done;
      logic rsp_free;
      logic clear_done;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/hpfa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpfa_req_if
// Request channel: allocate or free command with the page byte address.
// ----------------------------------------------------------------------------
interface hpfa_req_if import hpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] page_address;

   modport source (output valid, command, page_address, input ready);
   modport sink   (input valid, command, page_address, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hpfa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpfa_rsp_if
// Response channel: allocated page address and completion status.
// ----------------------------------------------------------------------------
interface hpfa_rsp_if import hpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] alloc_address;
   logic [ST_W-1:0]   status;

   modport source (output valid, alloc_address, status, input ready);
   modport sink   (input valid, alloc_address, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hpfa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpfa_dp
// Allocator datapath: page count register, free stack memory, used-page
// bitmap memory with its byte scanner, and the response register.
// ----------------------------------------------------------------------------
module hpfa_dp import hpfa_pkg::*; #(
   parameter int STACK_DEPTH = 256,
   parameter int NUM_PAGES   = 4096,
   parameter int PAGE_SHIFT  = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [PC_W-1:0]      csr_wr_data,
   input  wire logic                 req_command,
   input  wire logic [ADDR_W-1:0]    req_page_address,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [ADDR_W-1:0]         rsp_alloc_address,
   output logic [ST_W-1:0]           rsp_status,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             stat
);

   localparam int SIDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int MAP_PAGES = (NUM_PAGES < PC_MAX_EFF) ? NUM_PAGES : PC_MAX_EFF;
   localparam int MAP_WORDS = (MAP_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SCN_W     = $clog2(MAP_WORDS + 1);
   localparam int EW_W      = PC_W + 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);

   // configuration
   logic [PC_W-1:0] page_count_ff;
   logic [PC_W-1:0] pc_round;
   logic [PC_W-1:0] eff_pages;
   logic [EW_W-1:0] eff_words;

   // latched request
   logic              req_cmd_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [ADDR_W-1:0] page_idx;
   logic [MW_W-1:0]   free_word;
   logic [BIT_W-1:0]  free_bit;

   // free stack
   logic [SIDX_W-1:0] stack_mem [STACK_DEPTH];
   logic [SIDX_W-1:0] stack_rd_ff;
   logic [CNT_W-1:0]  stack_cnt_ff;
   logic [CNT_W-1:0]  stack_cnt_in;
   logic [CNT_W-1:0]  stack_top;

   // used-page bitmap
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] map_rd_ff;
   logic [MW_W-1:0]          map_raddr;
   logic                     map_we;
   logic [MW_W-1:0]          map_waddr;
   logic [MAP_WORD_BITS-1:0] map_wdata;
   logic [MW_W-1:0]          clr_addr_ff;

   // scanner
   logic [SCN_W-1:0]         scan_addr_ff;
   logic [SCN_W-1:0]         scan_addr_in;
   logic                     scan_more;
   logic                     pend_ff;
   logic                     pend_in;
   logic [MW_W-1:0]          pend_addr_ff;
   logic [MAP_WORD_BITS-1:0] free_bits;
   logic [BIT_W-1:0]         hit_bit;

   // result and response
   logic [ADDR_W-1:0] res_addr_ff;
   rsp_status_type    res_status_ff;
   logic [ADDR_W-1:0] res_addr_in;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   rsp_status_type    rsp_status_ff;

   always_comb begin
      pc_round  = {page_count_ff[PC_W-1:BIT_W], BIT_W'(0)};
      eff_pages = (pc_round > PC_W'(MAP_PAGES)) ? PC_W'(MAP_PAGES) : pc_round;
      eff_words = (EW_W'(eff_pages) + EW_W'(MAP_WORD_BITS - 1)) >> BIT_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PC_W'(PC_RESET);
      end else if (csr_wr_en) begin
         page_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         req_cmd_ff  <= req_command;
         req_addr_ff <= req_page_address;
      end
   end

   always_comb begin
      page_idx  = req_addr_ff >> PAGE_SHIFT;
      free_word = page_idx[MW_W+BIT_W-1:BIT_W];
      free_bit  = page_idx[BIT_W-1:0];
   end

   // ---------------- free stack ----------------
   always_comb begin
      stack_top    = stack_cnt_ff - CNT_W'(1);
      stack_cnt_in = stack_cnt_ff;
      if (cmd.stk_rd_en) begin
         stack_cnt_in = stack_top;
      end else if (cmd.stk_wr_en) begin
         stack_cnt_in = stack_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_cnt_ff <= '0;
      end else begin
         stack_cnt_ff <= stack_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stk_wr_en) begin
         stack_mem[stack_cnt_ff[SIDX_W-1:0]] <= page_idx[SIDX_W-1:0];
      end
      if (cmd.stk_rd_en) begin
         stack_rd_ff <= stack_mem[stack_top[SIDX_W-1:0]];
      end
   end

   // ---------------- bitmap scanner ----------------
   always_comb begin
      scan_more    = EW_W'(scan_addr_ff) < eff_words;
      scan_addr_in = scan_addr_ff;
      pend_in      = 1'b0;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
      end else if (cmd.scan_run && scan_more) begin
         scan_addr_in = scan_addr_ff + SCN_W'(1);
         pend_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         pend_ff      <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_in) begin
         pend_addr_ff <= scan_addr_ff[MW_W-1:0];
      end
   end

   // bits at or above the effective page count count as used
   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         free_bits[b] = !map_rd_ff[b] &&
            (((EW_W'(pend_addr_ff) << BIT_W) + EW_W'(b)) < EW_W'(eff_pages));
      end
      hit_bit = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   // ---------------- bitmap memory ----------------
   always_comb begin
      map_raddr = cmd.map_free_rd ? free_word : scan_addr_ff[MW_W-1:0];
      map_we    = 1'b0;
      map_waddr = clr_addr_ff;
      map_wdata = '1;
      if (cmd.clear_run) begin
         map_we = 1'b1;
      end else if (cmd.map_free_wr) begin
         map_we    = 1'b1;
         map_waddr = free_word;
         map_wdata = map_rd_ff & ~(MAP_WORD_BITS'(1) << free_bit);
      end else if (cmd.scan_run && stat.scan_hit) begin
         map_we    = 1'b1;
         map_waddr = pend_addr_ff;
         map_wdata = map_rd_ff | (MAP_WORD_BITS'(1) << hit_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_run) begin
         clr_addr_ff <= clr_addr_ff + MW_W'(1);
      end
   end

   // ---------------- result and response ----------------
   always_comb begin
      case (cmd.res_src)
         SRC_STACK: res_addr_in = ADDR_W'(stack_rd_ff) << PAGE_SHIFT;
         SRC_SCAN:  res_addr_in = ((ADDR_W'(pend_addr_ff) << BIT_W) | ADDR_W'(hit_bit))
                                  << PAGE_SHIFT;
         default:   res_addr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_addr_ff   <= res_addr_in;
         res_status_ff <= cmd.res_status;
      end
      if (cmd.rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   always_comb begin
      stat.cmd_free     = (req_cmd_ff == CMD_FREE);
      stat.stack_empty  = (stack_cnt_ff == '0);
      stat.stack_full   = (stack_cnt_ff == CNT_W'(STACK_DEPTH));
      stat.low_page     = page_idx < ADDR_W'(STACK_DEPTH);
      stat.out_of_range = page_idx >= ADDR_W'(eff_pages);
      stat.scan_hit     = pend_ff && (free_bits != '0);
      stat.scan_done    = !pend_ff && !scan_more;
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
      stat.clear_done   = (clr_addr_ff == MW_W'(MAP_WORDS - 1));
   end

endmodule
`default_nettype wire

FILE: hw/rtl/hpfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpfa_ctrl
// Allocator controller: sequences the bitmap clear after reset, request
// decode, stack pop/push, bitmap scan or clear, and response hand-off.
// ----------------------------------------------------------------------------
module hpfa_ctrl import hpfa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type stat,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_src    = SRC_ZERO;
      cmd.res_status = ST_OK;
      req_ready      = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_take = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.cmd_free) begin
               if (!stat.stack_empty) begin
                  cmd.stk_rd_en = 1'b1;
                  state_in      = S_POP;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end else if (stat.low_page) begin
               // low pages always go to the stack, never to the bitmap
               cmd.res_load = 1'b1;
               if (stat.stack_full) begin
                  cmd.res_status = ST_FULL;
               end else begin
                  cmd.stk_wr_en = 1'b1;
               end
               state_in = S_FINISH;
            end else if (stat.out_of_range) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_RANGE;
               state_in       = S_FINISH;
            end else begin
               cmd.map_free_rd = 1'b1;
               state_in        = S_FREE_WR;
            end
         end
         S_POP: begin
            cmd.res_load = 1'b1;
            cmd.res_src  = SRC_STACK;
            state_in     = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_hit) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = SRC_SCAN;
               state_in     = S_FINISH;
            end else if (stat.scan_done) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OOM;
               state_in       = S_FINISH;
            end
         end
         S_FREE_WR: begin
            cmd.map_free_wr = 1'b1;
            cmd.res_load    = 1'b1;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/hybrid_page_frame_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hybrid_page_frame_allocator_top
// Physical page allocator: a free stack for low pages in front of a
// first-fit used-page bitmap, one response per request.
// ----------------------------------------------------------------------------
// throughput: one request at a time; the byte-wide bitmap read port sets the
//   scan rate of 8 pages per cycle
// reset: after reset a clearing pass marks every page used, one map byte per
//   cycle, before any request is taken
// ----------------------------------------------------------------------------
module hybrid_page_frame_allocator_top import hpfa_pkg::*; #(
   parameter int STACK_DEPTH = 256,
   parameter int NUM_PAGES   = 4096,
   parameter int PAGE_SHIFT  = 12
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic [PC_W-1:0] csr_wr_data,
   hpfa_req_if.sink             req_chan,
   hpfa_rsp_if.source           rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   hpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hpfa_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_PAGES   (NUM_PAGES),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_command       (req_chan.command),
      .req_page_address  (req_chan.page_address),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_alloc_address (rsp_chan.alloc_address),
      .rsp_status        (rsp_chan.status),
      .cmd               (cmd),
      .stat              (stat)
   );

   // one request in flight: no new request right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while another is in flight");

   // the response register is only reloaded once the previous one is gone
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response overwritten before it was taken");

   // at most one writer of the bitmap in any cycle
   a_map_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_run, cmd.map_free_wr, cmd.scan_run && stat.scan_hit}))
      else $error("bitmap written from two sources");

   // stack push and pop never coincide
   a_stack_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.stk_wr_en && cmd.stk_rd_en))
      else $error("stack push and pop in the same cycle");

endmodule
`default_nettype wire

FILE: verif/hpfa_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpfa_alloc_checker
// Watches the request, response and register ports of the page allocator,
// keeps its own copy of the free stack, the used-page map and the page
// count, predicts the reply to every accepted request and compares each
// accepted response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hpfa_alloc_checker import hpfa_pkg::*; #(
   parameter int STACK_DEPTH = 256,
   parameter int NUM_PAGES   = 4096,
   parameter int PAGE_SHIFT  = 12
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic [PC_W-1:0] csr_wr_data,
   hpfa_req_if                  req_mon,
   hpfa_rsp_if                  rsp_mon,
   output int                   fail_total,
   output int                   outstanding
);

   localparam int IDX_W   = ADDR_W - PAGE_SHIFT;
   localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [ADDR_W-1:0] alloc_address;
      rsp_status_type    status;
   } page_reply_type;

   logic [PC_W-1:0]    page_limit;
   logic [IDX_W-1:0]   low_stack [STACK_DEPTH];
   logic [COUNT_W-1:0] stack_fill;
   bit                 used_map [NUM_PAGES];
   page_reply_type     pending_replies [$];
   page_reply_type     want;

   // page count rounded down to whole map bytes, capped at the map size
   function automatic int unsigned usable_pages();
      int unsigned n;
      n = int'(page_limit) & ~32'd7;
      if (n > NUM_PAGES) begin
         n = NUM_PAGES;
      end
      return n;
   endfunction

   function automatic logic [ADDR_W-1:0] page_addr(input logic [IDX_W-1:0] idx);
      logic [63:0] wide;
      wide = 64'(idx) << PAGE_SHIFT;
      return wide[ADDR_W-1:0];
   endfunction

   task automatic allocate_or_free(input req_cmd_type cmd, input logic [ADDR_W-1:0] addr,
                                   output page_reply_type reply);
      logic [IDX_W-1:0] idx;
      int unsigned      span;
      bit               found;
      reply.alloc_address = '0;
      reply.status        = ST_OK;
      span                = usable_pages();
      found               = 1'b0;
      if (cmd == CMD_ALLOC) begin
         if (stack_fill != 0) begin
            stack_fill--;
            reply.alloc_address = page_addr(low_stack[stack_fill]);
         end else begin
            for (int i = 0; i < int'(span) && !found; i++) begin
               if (!used_map[i]) begin
                  used_map[i]         = 1'b1;
                  reply.alloc_address = page_addr(IDX_W'(i));
                  found               = 1'b1;
               end
            end
            if (!found) begin
               reply.status = ST_OOM;
            end
         end
      end else begin
         idx = addr[ADDR_W-1:PAGE_SHIFT];
         if (idx < STACK_DEPTH) begin
            // low pages bypass the map and the page count
            if (stack_fill >= STACK_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               low_stack[stack_fill] = idx;
               stack_fill++;
            end
         end else if (idx >= span) begin
            reply.status = ST_RANGE;
         end else begin
            used_map[idx] = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         page_limit = PC_W'(PC_RESET);
         stack_fill = '0;
         foreach (used_map[i]) begin
            used_map[i] = 1'b1;
         end
         foreach (low_stack[i]) begin
            low_stack[i] = '0;
         end
         pending_replies.delete();
      end else begin
         if (csr_wr_en) begin
            page_limit = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: response with no request outstanding: addr %h status %0d",
                        $time, rsp_mon.alloc_address, rsp_mon.status);
               fail_total++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_mon.alloc_address !== want.alloc_address) begin
                  $display("%0t: alloc_address mismatch, expected %h actual %h",
                           $time, want.alloc_address, rsp_mon.alloc_address);
                  fail_total++;
               end
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_mon.status);
                  fail_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            allocate_or_free(req_cmd_type'(req_mon.command), req_mon.page_address, want);
            pending_replies.push_back(want);
         end
      end
      outstanding = pending_replies.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the hybrid page frame allocator: a directed opening over the
// stack, the bitmap scan and the OK, out-of-memory and range statuses, then phases of random requests
// under different page counts and idle patterns, one of them with a long
// response hold-off. Checking is done by hpfa_alloc_checker.
// ----------------------------------------------------------------------------
module testbench;
   import hpfa_pkg::*;

   localparam int STACK_DEPTH = 256;
   localparam int NUM_PAGES   = 4096;
   localparam int PAGE_SHIFT  = 12;
   localparam int IDX_W       = ADDR_W - PAGE_SHIFT;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 600;

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic [PC_W-1:0] csr_wr_data;
   int              fail_total;
   int              outstanding;

   int              send_idle_pct;
   int              stall_pct;
   int unsigned     page_span;
   bit              hold_trigger;
   bit              hold_seen;
   int              hold_left;

   hpfa_req_if req_chan ();
   hpfa_rsp_if rsp_chan ();

   hybrid_page_frame_allocator_top #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_PAGES   (NUM_PAGES),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   hpfa_alloc_checker #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_PAGES   (NUM_PAGES),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_total  (fail_total),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // response side: random stalls, plus one long hold-off when triggered
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_seen      <= hold_trigger;
         hold_left      <= 0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen      <= hold_trigger;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input req_cmd_type cmd, input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.page_address <= addr;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic pick_request(input int free_pct, input int low_pct,
                               output req_cmd_type cmd, output logic [ADDR_W-1:0] addr);
      logic [IDX_W-1:0] idx;
      int               roll;
      roll = $urandom_range(99);
      addr = $urandom;
      if ($urandom_range(99) >= free_pct) begin
         cmd = CMD_ALLOC;
         if (roll < 50) begin
            addr = '0;
         end
      end else begin
         cmd = CMD_FREE;
         if (roll < low_pct) begin
            idx = IDX_W'($urandom_range(STACK_DEPTH - 1));
         end else if (roll < 95) begin
            if (page_span > STACK_DEPTH) begin
               idx = IDX_W'($urandom_range(page_span - 1, STACK_DEPTH));
            end else begin
               idx = IDX_W'($urandom_range(NUM_PAGES - 1, STACK_DEPTH));
            end
         end else begin
            idx = IDX_W'($urandom_range((2 ** IDX_W) - 1, page_span));
         end
         if ($urandom_range(1) == 0) begin
            addr[PAGE_SHIFT-1:0] = '0;
         end
         // a few frees keep a fully random address
         if (roll < 98) begin
            addr[ADDR_W-1:PAGE_SHIFT] = idx;
         end
      end
   endtask

   task automatic drain_replies();
      req_chan.valid <= 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input logic [PC_W-1:0] pages, input int idle_pct,
                            input int stall, input int count, input int free_pct,
                            input int low_pct, input bit squeeze);
      req_cmd_type       cmd;
      logic [ADDR_W-1:0] addr;
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pages;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
      page_span     = (int'(pages) / 8) * 8;
      if (page_span > NUM_PAGES) begin
         page_span = NUM_PAGES;
      end
      send_idle_pct = idle_pct;
      stall_pct     <= stall;
      if (squeeze) begin
         hold_trigger <= ~hold_trigger;
      end
      repeat (count) begin
         pick_request(free_pct, low_pct, cmd, addr);
         send_request(cmd, addr);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_ALLOC;
      req_chan.page_address = '0;
      send_idle_pct         = 0;
      stall_pct             = 0;
      page_span             = NUM_PAGES;
      hold_trigger          = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // whole map used at reset: nothing to hand out
      send_request(CMD_ALLOC, 32'h0000_0000);
      // unaligned low page goes to the stack, comes back aligned
      send_request(CMD_FREE,  32'h0000_0FFF);
      send_request(CMD_ALLOC, 32'hFFFF_FFFF);
      send_request(CMD_FREE,  32'h0012_3ABC);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_FREE,  32'hFFFF_FFFF);
      send_request(CMD_FREE,  32'h0010_0000);
      send_request(CMD_FREE,  32'h00FF_F000);
      send_request(CMD_FREE,  32'h0100_0000);
      send_request(CMD_FREE,  32'h000F_F000);
      send_request(CMD_FREE,  32'h0000_1000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      // double free on the map, then on the stack
      send_request(CMD_FREE,  32'h0010_0000);
      send_request(CMD_FREE,  32'h0010_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_FREE,  32'h0000_5000);
      send_request(CMD_FREE,  32'h0000_5000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_ALLOC, 32'h0000_0000);
      send_request(CMD_FREE,  32'h0000_0000);

      run_phase(13'd512,  0,  0,  200, 50, 40, 1'b0);
      run_phase(13'd1024, 80, 0,  150, 50, 30, 1'b0);
      run_phase(13'd13,   0,  80, 120, 50, 50, 1'b0);
      // mostly low frees fill the stack; responses held off at the start
      run_phase(13'd300,  10, 10, 400, 95, 95, 1'b1);
      run_phase(13'd2048, 0,  0,  150, 15, 50, 1'b0);
      run_phase(13'd0,    80, 0,  40,  50, 50, 1'b0);
      run_phase(13'd8191, 10, 10, 60,  50, 30, 1'b0);
      run_phase(13'd640,  0,  80, 150, 50, 40, 1'b0);
      run_phase(13'd1000, 0,  0,  150, 50, 40, 1'b0);

      drain_replies();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_total == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/hpfa_pkg.sv
hw/rtl/hpfa_req_if.sv
hw/rtl/hpfa_rsp_if.sv
hw/rtl/hpfa_dp.sv
hw/rtl/hpfa_ctrl.sv
hw/rtl/hybrid_page_frame_allocator_top.sv
verif/hpfa_alloc_checker.sv
verif/testbench.sv
